@@ hw/rtl/imav_pkg.sv @@
// Shared types and constants for the IMU moving-average calibrator.
// Used by imav_cell, imav_lane and imu_moving_average_calibrator.
`default_nettype none

package imav_pkg;

    localparam int WINDOW_LENGTH = 10;
    localparam int CHANNELS      = 6;
    localparam int SAMPLE_W      = 16;
    localparam int TIME_W        = 24;
    localparam int GAIN_W        = 16;
    localparam int GAIN_SHIFT    = 14;
    localparam int GAINS_W       = 3 * GAIN_W;
    localparam int CFG_DATA_W    = GAINS_W;
    localparam int CFG_ADDR_W    = 3;
    localparam int TDATA_W       = CHANNELS * SAMPLE_W + TIME_W;

    // Running sum of one channel over the window
    localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_LENGTH);
    // Reciprocal multiply for |sum| / WINDOW_LENGTH
    localparam int RECIP_K = SUM_W + $clog2(WINDOW_LENGTH) + 1;
    localparam int RECIP_W = RECIP_K - $clog2(WINDOW_LENGTH) + 1;
    localparam longint RECIP = ((64'd1 << RECIP_K) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
    localparam int QUO_W   = SAMPLE_W + 1;
    localparam int DIFF_W  = SAMPLE_W + 2;
    localparam int PROD_W  = DIFF_W + GAIN_W + 1;
    localparam int SCALED_W = PROD_W - GAIN_SHIFT;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN  = GAIN_W'(1 << GAIN_SHIFT);
    localparam logic [GAINS_W-1:0] GAINS_RESET = {UNITY_GAIN, UNITY_GAIN, UNITY_GAIN};

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_GYRO_BIAS_X  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GYRO_BIAS_Y  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GYRO_BIAS_Z  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_BIAS_X = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_BIAS_Y = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_BIAS_Z = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_GAINS  = 3'd6;

    // Channel order: gyro x, y, z, accel x, y, z
    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] frame_t;

    // Stage load strobes shared by all lanes
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
        logic load4;
    } pipe_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/imav_cell.sv @@
// One tap of the sample history: holds a six-channel frame and passes it on.
// Depends on imav_pkg.
`default_nettype none

module imav_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            shift_en,
    input  wire imav_pkg::frame_t d_in,
    output imav_pkg::frame_t     q_out
);

    imav_pkg::frame_t frame_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= '0;
        end else if (shift_en) begin
            frame_reg <= d_in;
        end
    end

    assign q_out = frame_reg;

endmodule

`default_nettype wire

@@ hw/rtl/imav_lane.sv @@
// Per-channel datapath: running sum, divide by window, debias, gain, saturate.
// Depends on imav_pkg; pipeline strobes come from the top level.
`default_nettype none

module imav_lane (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire imav_pkg::pipe_ctl_t                 ctl,
    input  wire logic signed [imav_pkg::SAMPLE_W-1:0] new_sample,
    input  wire logic signed [imav_pkg::SAMPLE_W-1:0] old_sample,
    input  wire logic signed [imav_pkg::SAMPLE_W-1:0] bias,
    input  wire logic        [imav_pkg::GAIN_W-1:0]   gain,
    output logic signed [imav_pkg::SAMPLE_W-1:0]      result
);

    localparam int SUM_W    = imav_pkg::SUM_W;
    localparam int QUO_W    = imav_pkg::QUO_W;
    localparam int DIFF_W   = imav_pkg::DIFF_W;
    localparam int PROD_W   = imav_pkg::PROD_W;
    localparam int SCALED_W = imav_pkg::SCALED_W;
    localparam int MUL_W    = SUM_W + imav_pkg::RECIP_W;
    localparam logic [imav_pkg::RECIP_W-1:0] RECIP = imav_pkg::RECIP_W'(imav_pkg::RECIP);
    localparam logic signed [SCALED_W-1:0] SAT_MAX = SCALED_W'(32767);
    localparam logic signed [SCALED_W-1:0] SAT_MIN = -SCALED_W'(32768);
    localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'((1 << imav_pkg::GAIN_SHIFT) - 1);

    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic        [QUO_W-1:0]    quo_reg;
    logic                       neg_reg;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [imav_pkg::SAMPLE_W-1:0] result_reg, result_next;

    logic        [SUM_W-1:0]    abs_sum;
    logic        [MUL_W-1:0]    recip_prod;
    logic signed [DIFF_W-1:0]   mean, diff;
    logic signed [PROD_W-1:0]   prod_adj;
    logic signed [SCALED_W-1:0] scaled;

    // Ring update: add the entering sample, drop the one leaving the window
    always_comb begin
        sum_next = sum_reg + SUM_W'(new_sample) - SUM_W'(old_sample);
    end

    // Truncating divide by the window length through a reciprocal multiply
    always_comb begin
        abs_sum    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        recip_prod = MUL_W'(abs_sum) * MUL_W'(RECIP);
    end

    always_comb begin
        mean      = neg_reg ? -DIFF_W'(quo_reg) : DIFF_W'(quo_reg);
        diff      = mean - DIFF_W'(bias);
        prod_next = PROD_W'(diff) * $signed({{(PROD_W - imav_pkg::GAIN_W){1'b0}}, gain});
    end

    // Shift right by the gain's fraction, rounding toward zero, then saturate
    always_comb begin
        prod_adj = prod_reg[PROD_W-1] ? prod_reg + $signed(ROUND_BIAS) : prod_reg;
        scaled   = SCALED_W'(prod_adj >>> imav_pkg::GAIN_SHIFT);
        if (scaled > SAT_MAX) begin
            result_next = imav_pkg::SAMPLE_W'(SAT_MAX);
        end else if (scaled < SAT_MIN) begin
            result_next = imav_pkg::SAMPLE_W'(SAT_MIN);
        end else begin
            result_next = imav_pkg::SAMPLE_W'(scaled);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctl.load1) begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load2) begin
            quo_reg <= recip_prod[imav_pkg::RECIP_K +: QUO_W];
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (ctl.load3) begin
            prod_reg <= prod_next;
        end
        if (ctl.load4) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

@@ hw/rtl/imu_moving_average_calibrator.sv @@
// Top level of the IMU moving-average calibrator: history chain, lanes, control.
// Depends on imav_pkg, imav_cell and imav_lane.
//
// Usage:
//   s_ channel takes one frame per beat; m_ channel returns one calibrated
//   frame per accepted input beat, in order. Configuration is written through
//   cfg_wr_en / cfg_addr / cfg_wdata while no frame is in flight.
//   Each beat enters a chain of WINDOW_LENGTH cells; the cell falling off the
//   end is subtracted from each channel's running sum in the same cycle.
//   Each beat passes through registered stages in order before reaching m_
//   (sum update, reciprocal divide, bias and gain multiply, saturation).
//   Throughput: one frame per cycle while m_tready is high; each pipeline stage
//   has a valid bit and moves whenever the stage after it is empty or moving.
//   When the receiver stalls, the output register holds its beat and the
//   earlier stages keep filling; s_tready drops only once all stages are full.
//   Reset clears the history cells, the running sums, the biases (to zero)
//   and the gains (to 1.0 in Q2.14); no clearing pass is needed.
//   s_tready stays low while reset is held.
`default_nettype none

module imu_moving_average_calibrator (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // gyro_x_raw, gyro_y_raw, gyro_z_raw, accel_x_raw, accel_y_raw,
    // accel_z_raw, sensor_time_in
    input  wire logic [imav_pkg::TDATA_W-1:0]       s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, sensor_time
    output logic [imav_pkg::TDATA_W-1:0]            m_tdata,
    input  wire logic                               cfg_wr_en,
    input  wire logic [imav_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [imav_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int W      = imav_pkg::WINDOW_LENGTH;
    localparam int CH     = imav_pkg::CHANNELS;
    localparam int SW     = imav_pkg::SAMPLE_W;
    localparam int TW     = imav_pkg::TIME_W;
    localparam int GW     = imav_pkg::GAIN_W;

    logic [CH-1:0][SW-1:0]             bias_reg;
    logic [imav_pkg::GAINS_W-1:0]      gains_reg;

    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic [TW-1:0] t1_reg, t2_reg, t3_reg, to_reg;

    imav_pkg::pipe_ctl_t ctl;
    imav_pkg::frame_t    in_frame;
    imav_pkg::frame_t    cell_q [W];
    logic [CH-1:0][SW-1:0] lane_gain;
    logic [CH-1:0][SW-1:0] lane_res;
    logic accept;

    assign in_frame = s_tdata[CH*SW-1:0];

    // Stage strobes, back to front
    always_comb begin
        ctl.load4 = v3_reg && (!vo_reg || m_tready);
        ctl.load3 = v2_reg && (!v3_reg || ctl.load4);
        ctl.load2 = v1_reg && (!v2_reg || ctl.load3);
        s_tready  = aresetn && (!v1_reg || ctl.load2);
        accept    = s_tvalid && s_tready;
        ctl.load1 = accept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            v1_reg <= ctl.load1 || (v1_reg && !ctl.load2);
            v2_reg <= ctl.load2 || (v2_reg && !ctl.load3);
            v3_reg <= ctl.load3 || (v3_reg && !ctl.load4);
            vo_reg <= ctl.load4 || (vo_reg && !m_tready);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load1) begin
            t1_reg <= s_tdata[CH*SW +: TW];
        end
        if (ctl.load2) begin
            t2_reg <= t1_reg;
        end
        if (ctl.load3) begin
            t3_reg <= t2_reg;
        end
        if (ctl.load4) begin
            to_reg <= t3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg  <= '0;
            gains_reg <= imav_pkg::GAINS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                imav_pkg::REG_GYRO_BIAS_X:  bias_reg[0] <= cfg_wdata[SW-1:0];
                imav_pkg::REG_GYRO_BIAS_Y:  bias_reg[1] <= cfg_wdata[SW-1:0];
                imav_pkg::REG_GYRO_BIAS_Z:  bias_reg[2] <= cfg_wdata[SW-1:0];
                imav_pkg::REG_ACCEL_BIAS_X: bias_reg[3] <= cfg_wdata[SW-1:0];
                imav_pkg::REG_ACCEL_BIAS_Y: bias_reg[4] <= cfg_wdata[SW-1:0];
                imav_pkg::REG_ACCEL_BIAS_Z: bias_reg[5] <= cfg_wdata[SW-1:0];
                imav_pkg::REG_ACCEL_GAINS:  gains_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // History chain: newest frame in cell 0, oldest in the last cell
    for (genvar i = 0; i < W; i++) begin : g_cell
        if (i == 0) begin : g_head
            imav_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (ctl.load1),
                .d_in     (in_frame),
                .q_out    (cell_q[i])
            );
        end else begin : g_body
            imav_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (ctl.load1),
                .d_in     (cell_q[i-1]),
                .q_out    (cell_q[i])
            );
        end
    end

    // Gyro lanes run at unity gain, which leaves the difference unchanged
    assign lane_gain[0] = imav_pkg::UNITY_GAIN;
    assign lane_gain[1] = imav_pkg::UNITY_GAIN;
    assign lane_gain[2] = imav_pkg::UNITY_GAIN;
    assign lane_gain[3] = gains_reg[0*GW +: GW];
    assign lane_gain[4] = gains_reg[1*GW +: GW];
    assign lane_gain[5] = gains_reg[2*GW +: GW];

    for (genvar c = 0; c < CH; c++) begin : g_lane
        imav_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .new_sample (in_frame[c]),
            .old_sample (cell_q[W-1][c]),
            .bias       (bias_reg[c]),
            .gain       (lane_gain[c]),
            .result     (lane_res[c])
        );
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {to_reg, lane_res[2], lane_res[1], lane_res[0],
                       lane_res[5], lane_res[4], lane_res[3]};

endmodule

`default_nettype wire
